// ===== design/jsu_pkg.sv =====
// Package for the JSON string unescaper: item types, result kinds, error codes,
// phase encoding and the per-item result bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_ended;
    } text_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] error_code;
        logic       last;
    } result_item_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_UNTERMINATED = 4'd1;
    localparam logic [3:0] ERR_CONTROL      = 4'd2;
    localparam logic [3:0] ERR_OPEN_ESCAPE  = 4'd3;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd4;
    localparam logic [3:0] ERR_TRUNCATED_U  = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW      = 4'd7;
    localparam logic [3:0] ERR_LONE_HIGH    = 4'd8;
    localparam logic [3:0] ERR_LONE_LOW     = 4'd9;

    typedef enum logic [2:0] {
        PH_BODY    = 3'd0,
        PH_ESC     = 3'd1,
        PH_HEX     = 3'd2,
        PH_PAIR_BS = 3'd3,
        PH_PAIR_U  = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_count;
        logic [15:0] hex_value;
        logic [9:0]  high_bits;
        logic        bad_hex_seen;
        logic        in_low_half;
    } state_t;

    localparam state_t STATE_INIT = '{phase: PH_BODY, hex_count: 2'd0, hex_value: 16'd0,
                                      high_bits: 10'd0, bad_hex_seen: 1'b0,
                                      in_low_half: 1'b0};

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] error_code;
    } entry_t;

    typedef struct packed {
        logic [2:0]                   count;
        entry_t [MAX_RESULTS-1:0]     entry;
    } bundle_t;

endpackage

`default_nettype wire

// ===== design/jsu_decode.sv =====
// Combinational decode of one text item: next string state and the bundle of
// up to four results (UTF-8 bytes, done or error) that the item causes.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  var state_t     state,
    input  var text_item_t item,
    output state_t         state_next,
    output bundle_t        bundle
);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    function automatic bundle_t one_result(input logic [1:0] kind, input logic [7:0] data,
                                           input logic [3:0] code);
        bundle_t r;
        r = '0;
        r.count = 3'd1;
        r.entry[0] = '{kind: kind, data_byte: data, error_code: code};
        return r;
    endfunction

    function automatic entry_t data_entry(input logic [7:0] data);
        entry_t e;
        e = '{kind: KIND_DATA, data_byte: data, error_code: ERR_NONE};
        return e;
    endfunction

    function automatic bundle_t encode_cp(input logic [20:0] cp);
        bundle_t r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.count = 3'd1;
            r.entry[0] = data_entry(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            r.count = 3'd2;
            r.entry[0] = data_entry({3'b110, cp[10:6]});
            r.entry[1] = data_entry({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            r.count = 3'd3;
            r.entry[0] = data_entry({4'b1110, cp[15:12]});
            r.entry[1] = data_entry({2'b10, cp[11:6]});
            r.entry[2] = data_entry({2'b10, cp[5:0]});
        end else begin
            r.count = 3'd4;
            r.entry[0] = data_entry({5'b11110, cp[20:18]});
            r.entry[1] = data_entry({2'b10, cp[17:12]});
            r.entry[2] = data_entry({2'b10, cp[11:6]});
            r.entry[3] = data_entry({2'b10, cp[5:0]});
        end
        return r;
    endfunction

    function automatic state_t hex_start(input state_t s, input logic low_half);
        state_t r;
        r = s;
        r.phase = PH_HEX;
        r.hex_count = 2'd0;
        r.hex_value = 16'd0;
        r.bad_hex_seen = 1'b0;
        r.in_low_half = low_half;
        return r;
    endfunction

    logic [7:0]  b;
    logic        ended;
    logic        digit_ok;
    logic [3:0]  digit;
    logic [15:0] value;
    logic        value_is_high;
    logic        value_is_low;
    logic [20:0] pair_cp;

    assign b     = item.text_byte;
    assign ended = item.text_ended;

    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            digit = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            digit = b[3:0] + 4'd9;
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    assign value         = {state.hex_value[11:0], digit};
    assign value_is_high = (value >= 16'hD800) && (value <= 16'hDBFF);
    assign value_is_low  = (value >= 16'hDC00) && (value <= 16'hDFFF);
    assign pair_cp       = 21'h10000 + {1'b0, state.high_bits, value[9:0]};

    always_comb
    begin
        state_next = state;
        bundle     = '0;
        unique case (state.phase)
            PH_ESC:
            begin
                if (ended)
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_ERROR, 8'd0, ERR_OPEN_ESCAPE);
                end
                else
                begin
                    state_next.phase = PH_BODY;
                    unique case (b)
                        CH_QUOTE:     bundle = one_result(KIND_DATA, CH_QUOTE, ERR_NONE);
                        CH_BACKSLASH: bundle = one_result(KIND_DATA, CH_BACKSLASH, ERR_NONE);
                        CH_SLASH:     bundle = one_result(KIND_DATA, CH_SLASH, ERR_NONE);
                        CH_B:         bundle = one_result(KIND_DATA, 8'h08, ERR_NONE);
                        CH_F:         bundle = one_result(KIND_DATA, 8'h0C, ERR_NONE);
                        CH_N:         bundle = one_result(KIND_DATA, 8'h0A, ERR_NONE);
                        CH_R:         bundle = one_result(KIND_DATA, 8'h0D, ERR_NONE);
                        CH_T:         bundle = one_result(KIND_DATA, 8'h09, ERR_NONE);
                        CH_U:         state_next = hex_start(state, 1'b0);
                        default:
                        begin
                            state_next = STATE_INIT;
                            bundle = one_result(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE);
                        end
                    endcase
                end
            end
            PH_HEX:
            begin
                if (ended)
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_ERROR, 8'd0, ERR_TRUNCATED_U);
                end
                else
                begin
                    state_next.hex_value = value;
                    state_next.bad_hex_seen = state.bad_hex_seen | ~digit_ok;
                    if (state.hex_count != 2'd3)
                    begin
                        state_next.hex_count = state.hex_count + 2'd1;
                    end
                    else if (state.bad_hex_seen || !digit_ok)
                    begin
                        state_next = STATE_INIT;
                        bundle = one_result(KIND_ERROR, 8'd0, ERR_BAD_HEX);
                    end
                    else if (!state.in_low_half)
                    begin
                        if (value_is_high)
                        begin
                            state_next.high_bits = value[9:0];
                            state_next.phase = PH_PAIR_BS;
                        end
                        else if (value_is_low)
                        begin
                            state_next = STATE_INIT;
                            bundle = one_result(KIND_ERROR, 8'd0, ERR_LONE_LOW);
                        end
                        else
                        begin
                            state_next.phase = PH_BODY;
                            bundle = encode_cp({5'd0, value});
                        end
                    end
                    else if (!value_is_low)
                    begin
                        state_next = STATE_INIT;
                        bundle = one_result(KIND_ERROR, 8'd0, ERR_BAD_LOW);
                    end
                    else
                    begin
                        state_next = STATE_INIT;
                        bundle = encode_cp(pair_cp);
                    end
                end
            end
            PH_PAIR_BS:
            begin
                if (!ended && b == CH_BACKSLASH)
                begin
                    state_next.phase = PH_PAIR_U;
                end
                else
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_ERROR, 8'd0, ERR_LONE_HIGH);
                end
            end
            PH_PAIR_U:
            begin
                if (!ended && b == CH_U)
                begin
                    state_next = hex_start(state, 1'b1);
                end
                else
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_ERROR, 8'd0, ERR_LONE_HIGH);
                end
            end
            default:
            begin
                state_next.phase = PH_BODY;
                if (ended)
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_ERROR, 8'd0, ERR_UNTERMINATED);
                end
                else if (b == CH_QUOTE)
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_DONE, 8'd0, ERR_NONE);
                end
                else if (b < 8'h20)
                begin
                    state_next = STATE_INIT;
                    bundle = one_result(KIND_ERROR, 8'd0, ERR_CONTROL);
                end
                else if (b == CH_BACKSLASH)
                begin
                    state_next.phase = PH_ESC;
                end
                else
                begin
                    bundle = one_result(KIND_DATA, b, ERR_NONE);
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/json_string_unescape_utf8_core.sv =====
// Top level of the JSON string unescaper: string state register, result
// bundle register and the result serialiser.
// Depends on jsu_pkg and jsu_decode.
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a JSON string body per item and returns its decoded
// UTF-8 bytes, a done result at the closing quote, or one coded error. An
// item is decoded in the cycle it is accepted and its results are held in a
// bundle register that the result port drains at one result per cycle
// while result_ready is high. The text port is held while results of an
// item are pending; the next item is taken in the same cycle as the last
// result of the previous one, and items that yield no result pass at one
// per cycle.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  var logic         clk,
    input  var logic         rst_n,
    input  var logic         text_valid,
    output logic             text_ready,
    input  var text_item_t   text,
    output logic             result_valid,
    input  var logic         result_ready,
    output result_item_t     result
);

    state_t     state_reg;
    state_t     state_next;
    bundle_t    bundle_reg;
    bundle_t    bundle_next;
    logic [1:0] index_reg;
    logic       on_last;
    logic       take;
    entry_t     head;

    jsu_decode u_decode (
        .state      (state_reg),
        .item       (text),
        .state_next (state_next),
        .bundle     (bundle_next)
    );

    assign head         = bundle_reg.entry[index_reg];
    assign on_last      = ({1'b0, index_reg} == bundle_reg.count - 3'd1);
    assign result_valid = (bundle_reg.count != 3'd0);
    assign text_ready   = !result_valid || (result_ready && on_last);
    assign take         = text_valid && text_ready;

    assign result.kind       = head.kind;
    assign result.data_byte  = head.data_byte;
    assign result.error_code = head.error_code;
    assign result.last       = on_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= STATE_INIT;
            bundle_reg <= '0;
            index_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                state_reg  <= state_next;
                bundle_reg <= bundle_next;
                index_reg  <= 2'd0;
            end
            else if (result_valid && result_ready)
            begin
                if (on_last)
                begin
                    bundle_reg.count <= 3'd0;
                    index_reg        <= 2'd0;
                end
                else
                begin
                    index_reg <= index_reg + 2'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/jsu_checker.sv =====
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8_core.
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input var logic         clk,
    input var logic         rst_n,
    input var logic         text_ready,
    input var logic         result_valid,
    input var logic         result_ready,
    input var result_item_t result
);

    // A held result must not change until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // With nothing pending the block must take the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> text_ready)
    else $error("text port stalled with no pending result");

    // Done and error results always close the results of their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_DATA |-> result.last)
    else $error("done or error result not marked last");

    // An error code appears exactly on error results.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

    // A taken result that is not the last one is followed by more results.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last |=> result_valid)
    else $error("results of an item cut short");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_ready   (text_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
